// ===== rtl/stb_pkg.sv =====
// shared types and constants for the software timer bank
package stb_pkg;

  localparam int NUM_TIMERS = 128;
  localparam int IDX_W      = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;

  localparam logic [2:0] CMD_TICK           = 3'd0;
  localparam logic [2:0] CMD_START          = 3'd1;
  localparam logic [2:0] CMD_STOP           = 3'd2;
  localparam logic [2:0] CMD_NOT_RUNNING    = 3'd3;
  localparam logic [2:0] CMD_QUERY          = 3'd4;
  localparam logic [2:0] CMD_WRITE_DURATION = 3'd5;

  localparam logic [2:0] MODE_HALTED      = 3'd0;
  localparam logic [2:0] MODE_STARTED     = 3'd1;
  localparam logic [2:0] MODE_RUNNING     = 3'd2;
  localparam logic [2:0] MODE_ELAPSED     = 3'd3;
  localparam logic [2:0] MODE_NOT_RUNNING = 3'd4;

  typedef struct packed {
    logic [2:0]  command;
    logic [7:0]  timer_index;
    logic [31:0] duration_value;
  } in_t;

  typedef struct packed {
    logic [2:0]  timer_status;
    logic [15:0] elapsed_ticks;
    logic        index_valid;
  } out_t;

  // one memory word per timer
  typedef struct packed {
    logic [2:0]  mode;
    logic [31:0] stamp;
    logic [31:0] duration;
  } entry_t;

endpackage

// ===== rtl/software_timer_bank.sv =====
// software timer bank top level: command sequencer, timer memory and result register
// A bank of NUM_TIMERS one-shot timers sharing a 32-bit time base that each tick
// request advances by one. Each request carries a command, a timer index and a
// duration, and returns exactly one result. All per-timer state (mode, start stamp,
// duration) sits in one simple dual-port synchronous memory with one read and one
// write per cycle. A tick request increments the time base and sweeps every entry,
// reading one entry per cycle while the entry before it is written back; the block
// takes no new request until the sweep and the hand-off of its result are done.
// Start, stop, not running, query and write duration go through read, modify and
// write back, and hand-off; an out-of-range index or an unused command code goes
// straight to hand-off.
// One request is in flight at a time; a finished result waits in the output register
// and the next request is taken once the sequencer is back in idle. Reset clears a
// per-entry valid bit at once, and an entry never written reads as halted with zero
// stamp and duration, so there is no clearing pass after reset.
module software_timer_bank
  import stb_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  in_t  in_data,
  output logic out_valid,
  input  logic out_ready,
  output out_t out_data
);

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_TIMERS - 1);
  localparam logic [7:0]       NUM_8    = 8'(NUM_TIMERS);

  typedef enum logic [1:0] {ST_IDLE, ST_EXEC, ST_SCAN, ST_HOLD} state_t;

  // sequencer and datapath registers
  state_t            state_r, state_nxt;
  logic [31:0]       time_base_r, time_base_nxt;
  logic [2:0]        cmd_r, cmd_nxt;
  logic [IDX_W-1:0]  idx_r, idx_nxt;
  logic [31:0]       dur_r, dur_nxt;
  logic [IDX_W-1:0]  scan_idx_r, scan_idx_nxt;
  logic              issue_done_r, issue_done_nxt;
  logic              pend_r, pend_nxt;
  logic [IDX_W-1:0]  pend_addr_r, pend_addr_nxt;
  out_t              res_r, res_nxt;
  logic              out_valid_r, out_valid_nxt;
  out_t              out_data_r, out_data_nxt;

  // timer memory and its valid bits
  entry_t            mem [NUM_TIMERS];
  logic              vld_r [NUM_TIMERS];
  entry_t            rd_data_r;
  logic              rd_vld_r;
  logic              rd_en;
  logic [IDX_W-1:0]  rd_addr;
  logic              wr_en;
  logic [IDX_W-1:0]  wr_addr;
  entry_t            wr_data;

  entry_t            cur;        // entry as read, reset value if never written
  entry_t            upd;        // entry after the command or sweep step
  logic [31:0]       elapsed;
  logic              in_fire;
  logic              idx_ok;
  logic              out_free;

  assign in_ready  = (state_r == ST_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign out_free  = !out_valid_r || out_ready;
  assign idx_ok    = (in_data.timer_index < NUM_8);

  // an entry that was never written still holds its reset value
  always_comb begin
    if (rd_vld_r) begin
      cur = rd_data_r;
    end else begin
      cur = '0;
      cur.mode = MODE_HALTED;
    end
  end

  assign elapsed = time_base_r - cur.stamp;

  // modify step: per-command update in exec, timer advance in the sweep
  always_comb begin
    upd = cur;
    if (state_r == ST_SCAN) begin
      if (cur.mode == MODE_RUNNING && elapsed >= cur.duration) begin
        upd.mode = MODE_ELAPSED;
      end
      if (cur.mode == MODE_STARTED) begin
        upd.stamp = time_base_r;
        upd.mode  = MODE_RUNNING;
      end
    end else begin
      case (cmd_r)
        CMD_START:          upd.mode     = MODE_STARTED;
        CMD_STOP:           upd.mode     = MODE_HALTED;
        CMD_NOT_RUNNING:    upd.mode     = MODE_NOT_RUNNING;
        CMD_WRITE_DURATION: upd.duration = dur_r;
        default:            upd          = cur;
      endcase
    end
  end

  always_comb begin
    state_nxt      = state_r;
    time_base_nxt  = time_base_r;
    cmd_nxt        = cmd_r;
    idx_nxt        = idx_r;
    dur_nxt        = dur_r;
    scan_idx_nxt   = scan_idx_r;
    issue_done_nxt = issue_done_r;
    pend_nxt       = 1'b0;
    pend_addr_nxt  = pend_addr_r;
    res_nxt        = res_r;
    out_valid_nxt  = out_valid_r;
    out_data_nxt   = out_data_r;
    rd_en          = 1'b0;
    rd_addr        = scan_idx_r;
    wr_en          = 1'b0;
    wr_addr        = idx_r;
    wr_data        = upd;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          cmd_nxt = in_data.command;
          idx_nxt = in_data.timer_index[IDX_W-1:0];
          dur_nxt = in_data.duration_value;
          res_nxt = '0;
          if (in_data.command == CMD_TICK) begin
            // tick: bump the time base, then sweep every entry
            time_base_nxt  = time_base_r + 32'd1;
            scan_idx_nxt   = '0;
            issue_done_nxt = 1'b0;
            state_nxt      = ST_SCAN;
          end else if (in_data.command <= CMD_WRITE_DURATION && idx_ok) begin
            rd_en     = 1'b1;
            rd_addr   = in_data.timer_index[IDX_W-1:0];
            state_nxt = ST_EXEC;
          end else begin
            // unused code or index out of range: all-zero result
            state_nxt = ST_HOLD;
          end
        end
      end
      ST_EXEC: begin
        wr_en   = 1'b1;
        wr_addr = idx_r;
        res_nxt.timer_status  = upd.mode;
        res_nxt.elapsed_ticks = elapsed[15:0];
        res_nxt.index_valid   = 1'b1;
        state_nxt = ST_HOLD;
      end
      ST_SCAN: begin
        // read entry k while entry k-1 is written back
        if (!issue_done_r) begin
          rd_en         = 1'b1;
          rd_addr       = scan_idx_r;
          pend_nxt      = 1'b1;
          pend_addr_nxt = scan_idx_r;
          if (scan_idx_r == LAST_IDX) begin
            issue_done_nxt = 1'b1;
          end else begin
            scan_idx_nxt = scan_idx_r + 1'b1;
          end
        end
        if (pend_r) begin
          wr_en   = 1'b1;
          wr_addr = pend_addr_r;
          if (issue_done_r) begin
            state_nxt = ST_HOLD;
          end
        end
      end
      ST_HOLD: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = res_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      time_base_r  <= '0;
      issue_done_r <= 1'b0;
      pend_r       <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      time_base_r  <= time_base_nxt;
      issue_done_r <= issue_done_nxt;
      pend_r       <= pend_nxt;
      out_valid_r  <= out_valid_nxt;
    end
    cmd_r       <= cmd_nxt;
    idx_r       <= idx_nxt;
    dur_r       <= dur_nxt;
    scan_idx_r  <= scan_idx_nxt;
    pend_addr_r <= pend_addr_nxt;
    res_r       <= res_nxt;
    out_data_r  <= out_data_nxt;
  end

  // valid bits, cleared at once by reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_TIMERS; i++) begin
        vld_r[i] <= 1'b0;
      end
    end else if (wr_en) begin
      vld_r[wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_vld_r <= vld_r[rd_addr];
    end
  end

  // timer memory, one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

`ifndef SYNTH
  a_wr_phase: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |-> (state_r == ST_EXEC || state_r == ST_SCAN))
    else $error("memory write outside exec or sweep");

  a_no_rw_clash: assert property (@(posedge clk) disable iff (!rst_n)
    (wr_en && rd_en) |-> (wr_addr != rd_addr))
    else $error("read and write hit the same entry in one cycle");

  a_tick_bump: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_data.command == CMD_TICK) |=> (time_base_r == $past(time_base_r) + 32'd1))
    else $error("tick did not advance the time base");

  a_hold_only_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_HOLD && out_free) |=> (out_valid_r && state_r == ST_IDLE))
    else $error("finished result not handed to the output register");
`endif

endmodule
